>>> hw/rtl/gbi_pkg.sv
// ----------------------------------------------------------------------------
// gbi_pkg
// Shared types and constants of the grid bilinear interpolator.
// ----------------------------------------------------------------------------
package gbi_pkg;

	localparam int NUM_BANKS = 4;
	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED  = 3'd5;

	// item kinds
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic [31:0] INV_STEP_RESET = 32'h0001_0000;
	localparam logic [6:0]  COUNT_RESET    = 7'd64;
	localparam logic [16:0] ONE_Q16        = 17'h1_0000;

	typedef logic signed [31:0] sample_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic [31:0]        inv_step_x;
		logic [31:0]        inv_step_y;
		logic [6:0]         cols_used;
		logic [6:0]         rows_used;
	} cfg_t;

	typedef struct packed {
		logic               action;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic               pos_finite;
		logic [5:0]         cell_col;
		logic [5:0]         cell_row;
		sample_t            cell_value;
	} in_item_t;

	typedef struct packed {
		logic        action;
		logic        finite;
		logic        neg_x;
		logic        neg_y;
		logic [31:0] dx;
		logic [31:0] dy;
		logic [5:0]  col;
		logic [5:0]  row;
		sample_t     value;
	} item_s1_t;

	typedef struct packed {
		logic        action;
		logic        finite;
		logic        neg_x;
		logic        neg_y;
		logic [63:0] px;
		logic [63:0] py;
		logic [5:0]  col;
		logic [5:0]  row;
		sample_t     value;
	} item_s2_t;

	typedef struct packed {
		logic [15:0] fx;
		logic [15:0] fy;
		logic        xin;
		logic        yin;
		logic        in_grid;
		logic        ix0;
		logic        iy0;
	} query_ctl_t;

	typedef struct packed {
		logic       action;
		query_ctl_t ctl;
		logic [5:0] col;
		logic [5:0] row;
		sample_t    value;
	} loc_out_t;

endpackage

>>> hw/rtl/gbi_locate.sv
// ----------------------------------------------------------------------------
// gbi_locate
// Maps a point to a grid position: offset from origin, scale by the
// reciprocal step, then index range checks against the used grid size.
// ----------------------------------------------------------------------------
module gbi_locate #(
	parameter int GRID_COLS = 64,
	parameter int GRID_ROWS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gbi_pkg::cfg_t     cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  gbi_pkg::in_item_t in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output gbi_pkg::loc_out_t out_item,
	output logic [$clog2(GRID_COLS)-1:0] ix_lo,
	output logic [$clog2(GRID_ROWS)-1:0] iy_lo
);
	import gbi_pkg::*;

	localparam int IXW = $clog2(GRID_COLS);
	localparam int IYW = $clog2(GRID_ROWS);

	logic     valid_s1, valid_s2;
	item_s1_t item_s1;
	item_s2_t item_s2;
	logic     rdy1, rdy2;

	logic signed [32:0] dx_full, dy_full;
	logic [IXW-1:0]     last_x;
	logic [IYW-1:0]     last_y;
	logic [31:0]        ix_full, iy_full;
	logic               xin, xedge, yin, yedge;

	assign rdy2     = !valid_s2 || out_ready;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	assign dx_full = 33'(in_item.pos_x) - 33'(cfg.origin_x);
	assign dy_full = 33'(in_item.pos_y) - 33'(cfg.origin_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			item_s1.action <= in_item.action;
			item_s1.finite <= in_item.pos_finite;
			item_s1.neg_x  <= dx_full[32];
			item_s1.neg_y  <= dy_full[32];
			item_s1.dx     <= dx_full[31:0];
			item_s1.dy     <= dy_full[31:0];
			item_s1.col    <= in_item.cell_col;
			item_s1.row    <= in_item.cell_row;
			item_s1.value  <= in_item.cell_value;
		end
		if (valid_s1 && rdy2) begin
			item_s2.action <= item_s1.action;
			item_s2.finite <= item_s1.finite;
			item_s2.neg_x  <= item_s1.neg_x;
			item_s2.neg_y  <= item_s1.neg_y;
			item_s2.px     <= {32'd0, item_s1.dx} * {32'd0, cfg.inv_step_x};
			item_s2.py     <= {32'd0, item_s1.dy} * {32'd0, cfg.inv_step_y};
			item_s2.col    <= item_s1.col;
			item_s2.row    <= item_s1.row;
			item_s2.value  <= item_s1.value;
		end
	end

	// last usable index per axis, count clamped to [2, grid size]
	always_comb begin
		if (cfg.cols_used < 7'd2)
			last_x = IXW'(1);
		else if (32'(cfg.cols_used) > 32'(GRID_COLS))
			last_x = IXW'(GRID_COLS - 1);
		else
			last_x = IXW'(32'(cfg.cols_used) - 32'd1);
		if (cfg.rows_used < 7'd2)
			last_y = IYW'(1);
		else if (32'(cfg.rows_used) > 32'(GRID_ROWS))
			last_y = IYW'(GRID_ROWS - 1);
		else
			last_y = IYW'(32'(cfg.rows_used) - 32'd1);
	end

	assign ix_full = item_s2.px[63:32];
	assign iy_full = item_s2.py[63:32];
	assign xin     = ix_full <  32'(last_x);
	assign xedge   = ix_full == 32'(last_x);
	assign yin     = iy_full <  32'(last_y);
	assign yedge   = iy_full == 32'(last_y);

	always_comb begin
		out_item.action      = item_s2.action;
		out_item.ctl.fx      = item_s2.px[31:16];
		out_item.ctl.fy      = item_s2.py[31:16];
		out_item.ctl.xin     = xin;
		out_item.ctl.yin     = yin;
		out_item.ctl.in_grid = item_s2.finite && !item_s2.neg_x && !item_s2.neg_y &&
			(xin || xedge) && (yin || yedge);
		out_item.ctl.ix0     = item_s2.px[32];
		out_item.ctl.iy0     = item_s2.py[32];
		out_item.col         = item_s2.col;
		out_item.row         = item_s2.row;
		out_item.value       = item_s2.value;
	end

	assign out_valid = valid_s2;
	assign ix_lo     = item_s2.px[32 +: IXW];
	assign iy_lo     = item_s2.py[32 +: IYW];

	a_ix_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.ctl.in_grid |-> ix_full < 32'(GRID_COLS))
		else $error("in-grid point with column index past the grid");

	a_iy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.ctl.in_grid |-> iy_full < 32'(GRID_ROWS))
		else $error("in-grid point with row index past the grid");

endmodule

>>> hw/rtl/gbi_grid_mem.sv
// ----------------------------------------------------------------------------
// gbi_grid_mem
// Grid storage split in four banks by row and column parity, so the four
// corners of any cell come from four different banks, read in the same cycle.
// ----------------------------------------------------------------------------
module gbi_grid_mem #(
	parameter int GRID_COLS = 64,
	parameter int GRID_ROWS = 64
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [$clog2(GRID_COLS)-1:0] ix,
	input  logic [$clog2(GRID_ROWS)-1:0] iy,
	input  logic                         wr_en,
	input  logic [5:0]                   wr_col,
	input  logic [5:0]                   wr_row,
	input  gbi_pkg::sample_t             wr_data,
	output gbi_pkg::sample_t             rd_data [gbi_pkg::NUM_BANKS]
);
	import gbi_pkg::*;

	localparam int HALF_COLS  = (GRID_COLS + 1) / 2;
	localparam int HALF_ROWS  = (GRID_ROWS + 1) / 2;
	localparam int BANK_DEPTH = HALF_COLS * HALF_ROWS;
	localparam int BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

	logic            wr_ok;
	logic [1:0]      wr_bank;
	logic [BA_W-1:0] wr_addr;

	assign wr_ok   = (32'(wr_col) < 32'(GRID_COLS)) && (32'(wr_row) < 32'(GRID_ROWS));
	assign wr_bank = {wr_row[0], wr_col[0]};
	assign wr_addr = BA_W'(32'(wr_row >> 1) * 32'(HALF_COLS) + 32'(wr_col >> 1));

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		localparam bit PR = (b / 2) == 1;
		localparam bit PC = (b % 2) == 1;

		sample_t         bank_mem [BANK_DEPTH];
		logic [31:0]     hr, hc;
		logic [BA_W-1:0] rd_addr;

		// the bank of the odd neighbour holds the next half row / half column
		assign hr      = 32'(iy >> 1) + 32'(iy[0] & ~PR);
		assign hc      = 32'(ix >> 1) + 32'(ix[0] & ~PC);
		assign rd_addr = BA_W'(hr * 32'(HALF_COLS) + hc);

		always_ff @(posedge clk) begin
			if (wr_en && wr_ok && wr_bank == 2'(b))
				bank_mem[wr_addr] <= wr_data;
			if (rd_en)
				rd_data[b] <= bank_mem[rd_addr];
		end
	end

endmodule

>>> hw/rtl/gbi_blend.sv
// ----------------------------------------------------------------------------
// gbi_blend
// Bilinear weights, weighted sum of the four corner samples, rounding to
// Q16.16 and saturation, ending in the output register.
// ----------------------------------------------------------------------------
module gbi_blend (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  gbi_pkg::query_ctl_t in_ctl,
	input  gbi_pkg::sample_t    rd_data [gbi_pkg::NUM_BANKS],
	output logic                out_valid,
	input  logic                out_ready,
	output gbi_pkg::sample_t    estimate,
	output logic                in_grid
);
	import gbi_pkg::*;

	localparam logic signed [65:0] ROUND_HALF = 66'sh8000_0000;
	localparam logic signed [33:0] SAT_MAX    = 34'sh0_7FFF_FFFF;
	localparam logic signed [33:0] SAT_MIN    = -34'sh0_8000_0000;

	logic       valid_s3, valid_s4, valid_s5, valid_s6, valid_q;
	logic       rdy4, rdy5, rdy6, rdy_out;
	query_ctl_t ctl_s3;

	sample_t            samp_s4 [NUM_BANKS];
	logic [32:0]        w_s4 [NUM_BANKS];
	logic               in_grid_s4, in_grid_s5, in_grid_s6;
	logic signed [65:0] prod_s5 [NUM_BANKS];
	logic signed [65:0] sum_s6 [2];
	sample_t            estimate_q;
	logic               in_grid_q;

	logic [16:0]        wx0, wx1, wy0, wy1;
	sample_t            samp [NUM_BANKS];
	logic [32:0]        w [NUM_BANKS];
	logic signed [65:0] total;
	logic signed [33:0] rnd;
	sample_t            sat;

	assign rdy_out  = !valid_q || out_ready;
	assign rdy6     = !valid_s6 || rdy_out;
	assign rdy5     = !valid_s5 || rdy6;
	assign rdy4     = !valid_s4 || rdy5;
	assign in_ready = !valid_s3 || rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (in_ready) valid_s3 <= in_valid;
			if (rdy4)     valid_s4 <= valid_s3;
			if (rdy5)     valid_s5 <= valid_s4;
			if (rdy6)     valid_s6 <= valid_s5;
			if (rdy_out)  valid_q  <= valid_s6;
		end
	end

	// corner order: (y,x), (y,x+1), (y+1,x), (y+1,x+1); missing neighbours read 0
	always_comb begin
		wx1 = {1'b0, ctl_s3.fx};
		wx0 = ONE_Q16 - wx1;
		wy1 = {1'b0, ctl_s3.fy};
		wy0 = ONE_Q16 - wy1;
		w[0] = {16'd0, wx0} * {16'd0, wy0};
		w[1] = {16'd0, wx1} * {16'd0, wy0};
		w[2] = {16'd0, wx0} * {16'd0, wy1};
		w[3] = {16'd0, wx1} * {16'd0, wy1};
		samp[0] = rd_data[{ctl_s3.iy0, ctl_s3.ix0}];
		samp[1] = ctl_s3.xin ? rd_data[{ctl_s3.iy0, ~ctl_s3.ix0}] : '0;
		samp[2] = ctl_s3.yin ? rd_data[{~ctl_s3.iy0, ctl_s3.ix0}] : '0;
		samp[3] = (ctl_s3.xin && ctl_s3.yin) ? rd_data[{~ctl_s3.iy0, ~ctl_s3.ix0}] : '0;
	end

	always_comb begin
		total = sum_s6[0] + sum_s6[1] + ROUND_HALF;
		rnd   = total[65:32];
		if (rnd > SAT_MAX)
			sat = SAT_MAX[31:0];
		else if (rnd < SAT_MIN)
			sat = SAT_MIN[31:0];
		else
			sat = rnd[31:0];
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			ctl_s3 <= in_ctl;
		if (valid_s3 && rdy4) begin
			samp_s4    <= samp;
			w_s4       <= w;
			in_grid_s4 <= ctl_s3.in_grid;
		end
		if (valid_s4 && rdy5) begin
			for (int i = 0; i < NUM_BANKS; i++)
				prod_s5[i] <= $signed(66'(samp_s4[i]) * 66'(w_s4[i]));
			in_grid_s5 <= in_grid_s4;
		end
		if (valid_s5 && rdy6) begin
			sum_s6[0]  <= prod_s5[0] + prod_s5[1];
			sum_s6[1]  <= prod_s5[2] + prod_s5[3];
			in_grid_s6 <= in_grid_s5;
		end
		if (valid_s6 && rdy_out) begin
			estimate_q <= in_grid_s6 ? sat : '0;
			in_grid_q  <= in_grid_s6;
		end
	end

	assign out_valid = valid_q;
	assign estimate  = estimate_q;
	assign in_grid   = in_grid_q;

	a_weight_sum: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> 35'(w_s4[0]) + 35'(w_s4[1]) + 35'(w_s4[2]) + 35'(w_s4[3])
			== 35'h1_0000_0000)
		else $error("bilinear weights do not sum to one");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !in_grid_q |-> estimate_q == '0)
		else $error("nonzero estimate for a point outside the grid");

endmodule

>>> hw/rtl/grid_bilinear_interpolator_unit.sv
// ----------------------------------------------------------------------------
// grid_bilinear_interpolator_unit
// Bilinear interpolation over a stored regular grid of Q16.16 samples.
//
// s_* carries items: tuser = 0 writes cell (cell_row, cell_col), tuser = 1
// queries point (pos_x, pos_y). Writes give no beat on m_*. Each query gives
// one m_* beat: estimate in tdata, in_grid in tuser. cfg_* writes the
// origin, reciprocal step and used-size registers; cfg_ready is always high;
// the user must write registers only while no item is in flight, which the
// block does not enforce. Throughput: one item per cycle while m_tready is
// high, writes and queries mixed. The grid sits in four parity banks, so all
// four corners of a cell are read in the same cycle. A query passes stages
// s1 to s6 and the output register. Writes and reads take the memory in item
// order, so a query sees every earlier write. Reset clears the pipeline and
// loads the register defaults; grid contents are undefined until written.
// When m_tready is low the stages fill their empty slots, then s_tready falls.
// ----------------------------------------------------------------------------
module grid_bilinear_interpolator_unit #(
	parameter int GRID_COLS = 64,
	parameter int GRID_ROWS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,   // pos_x, pos_y, pos_finite, cell_col, cell_row, cell_value
	input  logic         s_tuser,   // action
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,   // estimate
	output logic         m_tuser,   // in_grid
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import gbi_pkg::*;

	localparam int IXW = $clog2(GRID_COLS);
	localparam int IYW = $clog2(GRID_ROWS);

	cfg_t       cfg_q;
	in_item_t   in_item;
	loc_out_t   loc_item;
	logic       loc_valid, loc_ready;
	logic [IXW-1:0] ix_lo;
	logic [IYW-1:0] iy_lo;
	logic       blend_valid, blend_ready;
	sample_t    rd_data [NUM_BANKS];
	sample_t    estimate;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x   <= '0;
			cfg_q.origin_y   <= '0;
			cfg_q.inv_step_x <= INV_STEP_RESET;
			cfg_q.inv_step_y <= INV_STEP_RESET;
			cfg_q.cols_used  <= COUNT_RESET;
			cfg_q.rows_used  <= COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ORIGIN_X:   cfg_q.origin_x   <= cfg_data;
				CFG_ORIGIN_Y:   cfg_q.origin_y   <= cfg_data;
				CFG_INV_STEP_X: cfg_q.inv_step_x <= cfg_data;
				CFG_INV_STEP_Y: cfg_q.inv_step_y <= cfg_data;
				CFG_COLS_USED:  cfg_q.cols_used  <= cfg_data[6:0];
				CFG_ROWS_USED:  cfg_q.rows_used  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		in_item.action     = s_tuser;
		in_item.pos_x      = s_tdata[31:0];
		in_item.pos_y      = s_tdata[63:32];
		in_item.pos_finite = s_tdata[64];
		in_item.cell_col   = s_tdata[70:65];
		in_item.cell_row   = s_tdata[76:71];
		in_item.cell_value = s_tdata[108:77];
	end

	// writes retire at the memory stage; queries move on to the blend pipe
	assign loc_ready   = (loc_item.action == ACT_WRITE) || blend_ready;
	assign blend_valid = loc_valid && (loc_item.action == ACT_QUERY);

	gbi_locate #(
		.GRID_COLS (GRID_COLS),
		.GRID_ROWS (GRID_ROWS)
	) u_locate (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.out_valid (loc_valid),
		.out_ready (loc_ready),
		.out_item  (loc_item),
		.ix_lo     (ix_lo),
		.iy_lo     (iy_lo)
	);

	gbi_grid_mem #(
		.GRID_COLS (GRID_COLS),
		.GRID_ROWS (GRID_ROWS)
	) u_grid_mem (
		.clk     (clk),
		.rd_en   (blend_ready),
		.ix      (ix_lo),
		.iy      (iy_lo),
		.wr_en   (loc_valid && (loc_item.action == ACT_WRITE)),
		.wr_col  (loc_item.col),
		.wr_row  (loc_item.row),
		.wr_data (loc_item.value),
		.rd_data (rd_data)
	);

	gbi_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (blend_valid),
		.in_ready  (blend_ready),
		.in_ctl    (loc_item.ctl),
		.rd_data   (rd_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.estimate  (estimate),
		.in_grid   (m_tuser)
	);

	assign m_tdata = estimate;

endmodule
